// ===== hw/rtl/mps_pkg.sv =====
// Shared types, widths and constants for the monthly period start date block.
// Used by mps_shift, mps_period and monthly_period_start_date; no dependencies.
package mps_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 12;
  localparam int SDAY_W   = 6;
  localparam int STAMP_W  = 25;

  // Internal year: signed, wide enough for the shifted and stepped-back year
  localparam int YINT_W   = 14;

  // Month indexes, zero based
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;
  localparam logic [MONTH_W-1:0] MON_MAX = 4'd12;

  // Shifted month, carried from the first stage to the second
  typedef struct packed {
    logic signed [YINT_W-1:0] year;
    logic [MONTH_W-1:0]       month;   // 0..11
    logic [DAY_W-1:0]         day;
  } shift_t;

  // Length of a zero-based month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] d;
    case (m) inside
      MON_FEB: d = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/mps_shift.sv =====
// Month shift: clamps the month, adds the signed offset and splits into year and month.
// Depends on mps_pkg.
module mps_shift
  import mps_pkg::*;
(
  input  logic [YEAR_W-1:0]          year,
  input  logic [MONTH_W-1:0]         month,
  input  logic [DAY_W-1:0]           day,
  input  logic signed [OFFSET_W-1:0] offset,
  output shift_t                     shifted
);

  // Bias keeps the month sum non-negative; it is a whole number of years
  localparam logic signed [YINT_W-1:0] BIAS_YEARS  = 14'sd171;
  localparam logic signed [YINT_W-1:0] BIAS_MONTHS = 14'sd2052;
  // Reciprocal of 12 scaled by 2^15, exact for sums below 8192
  localparam logic [24:0] RECIP12 = 25'd2731;

  logic [MONTH_W-1:0]       mon0;
  logic signed [YINT_W-1:0] msum;
  logic signed [YINT_W-1:0] mbias;
  logic [12:0]              u;
  logic [24:0]              prod;
  logic [8:0]               q;
  logic [12:0]              q12;
  logic [12:0]              rem;

  // Clamp the month into 1..12 and make it zero based
  always_comb begin
    if (month == 4'd0) begin
      mon0 = MON_JAN;
    end else if (month > MON_MAX) begin
      mon0 = MON_DEC;
    end else begin
      mon0 = month - 4'd1;
    end
  end

  // Total months relative to the input year, biased non-negative
  assign msum  = {{(YINT_W-OFFSET_W){offset[OFFSET_W-1]}}, offset}
               + signed'({{(YINT_W-MONTH_W){1'b0}}, mon0});
  assign mbias = msum + BIAS_MONTHS;
  assign u     = mbias[12:0];

  // Divide by twelve through the reciprocal, remainder by subtraction
  assign prod = 25'(u) * RECIP12;
  assign q    = prod[23:15];
  assign q12  = {1'b0, q, 3'b000} + {2'b00, q, 2'b00};
  assign rem  = u - q12;

  assign shifted.year  = signed'({{(YINT_W-YEAR_W){1'b0}}, year})
                       + signed'({{(YINT_W-9){1'b0}}, q}) - BIAS_YEARS;
  assign shifted.month = rem[MONTH_W-1:0];
  assign shifted.day   = day;

endmodule

// ===== hw/rtl/mps_period.sv =====
// Period resolve: leap rule, step back decision, start day and packed stamp.
// Depends on mps_pkg.
module mps_period
  import mps_pkg::*;
(
  input  shift_t                   shifted,
  input  logic signed [SDAY_W-1:0] start_day,
  output logic [YEAR_W-1:0]        period_year,
  output logic [MONTH_W-1:0]       period_month,
  output logic [DAY_W-1:0]         period_day,
  output logic [STAMP_W-1:0]       period_stamp
);

  // Bias of seven times 25 years keeps the year positive for the divide-by-25 test
  localparam logic signed [YINT_W-1:0] LEAP_BIAS = 14'sd175;
  // Reciprocal of 25 scaled by 2^18; a multiple of 25 leaves a small fraction
  localparam logic [26:0] RECIP25   = 27'd10486;
  localparam logic [17:0] FRAC_LIM  = 18'd2048;
  localparam logic [STAMP_W-1:0] YEAR_SCALE  = 25'd10000;
  localparam logic [STAMP_W-1:0] MONTH_SCALE = 25'd100;

  logic signed [YINT_W-1:0] ybias;
  logic [26:0]              prod;
  logic                     div25;
  logic                     leap;
  logic [DAY_W-1:0]         dim;
  logic [DAY_W-1:0]         dim2;
  logic signed [6:0]        sd7;
  logic signed [6:0]        day7;
  logic signed [6:0]        lim;
  logic signed [6:0]        sum2;
  logic                     pos;
  logic                     back;
  logic                     wrap;
  logic [MONTH_W-1:0]       mf;
  logic [MONTH_W-1:0]       mf1;
  logic [DAY_W-1:0]         date;
  logic signed [YINT_W-1:0] yf;
  logic [STAMP_W-1:0]       ym;
  logic [STAMP_W-1:0]       ymf;

  // Gregorian leap rule on the signed year
  assign ybias = shifted.year + LEAP_BIAS;
  assign prod  = 27'(ybias[12:0]) * RECIP25;
  assign div25 = prod[17:0] < FRAC_LIM;
  assign leap  = (shifted.year[1:0] == 2'b00) && (!div25 || shifted.year[3:0] == 4'd0);
  assign dim   = month_len(shifted.month, leap);

  // Step back one month when the day falls before this month's start
  assign sd7  = {start_day[SDAY_W-1], start_day};
  assign day7 = signed'({2'b00, shifted.day});
  assign pos  = !start_day[SDAY_W-1] && (start_day != '0);
  assign lim  = sd7 + signed'({2'b00, dim});
  assign back = pos ? (day7 < sd7) : (day7 < lim);
  assign wrap = back && (shifted.month == MON_JAN);

  always_comb begin
    if (!back) begin
      mf = shifted.month;
    end else if (wrap) begin
      mf = MON_DEC;
    end else begin
      mf = shifted.month - 4'd1;
    end
  end

  // Start day: fixed day, or counted from the month end and clamped
  assign dim2 = month_len(mf, leap);
  assign sum2 = sd7 + signed'({2'b00, dim2});

  always_comb begin
    if (pos) begin
      date = start_day[DAY_W-1:0];
    end else if (sum2 < 7'sd1) begin
      date = 5'd1;
    end else if (sum2 > signed'({2'b00, dim2})) begin
      date = dim2;
    end else begin
      date = sum2[DAY_W-1:0];
    end
  end

  // Packed stamp, wrapped to its width
  assign yf  = wrap ? shifted.year - 14'sd1 : shifted.year;
  assign ym  = {{(STAMP_W-YINT_W){shifted.year[YINT_W-1]}}, shifted.year} * YEAR_SCALE;
  assign ymf = wrap ? ym - YEAR_SCALE : ym;
  assign mf1 = mf + 4'd1;

  assign period_year  = yf[YEAR_W-1:0];
  assign period_month = mf1;
  assign period_day   = date;
  assign period_stamp = ymf + 25'(mf1) * MONTH_SCALE + 25'(date);

endmodule

// ===== hw/rtl/monthly_period_start_date.sv =====
// Monthly period start date: each input word is registered in stage one, then in the result register.
// Throughput one word per clock; the two-stage pipeline advances whenever the
// result register is empty or being taken, so stalls come only from m_tready.
// rst (synchronous, active high) empties the pipeline and sets start_day to 1.
// Top level; depends on mps_pkg, mps_shift and mps_period.
module monthly_period_start_date
  import mps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration: start_day
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,    // [5:0] start_day (signed)
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,     // [11:0] current_year, [15:12] current_month,
                                   // [20:16] current_day, [32:21] offset_months
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata      // [11:0] period_year, [15:12] period_month,
                                   // [20:16] period_day, [45:21] period_stamp
);

  logic signed [SDAY_W-1:0] start_day;
  logic                     adv;
  logic                     v1;
  shift_t                   s1_next;
  shift_t                   s1;
  logic [YEAR_W-1:0]        p_year;
  logic [MONTH_W-1:0]       p_month;
  logic [DAY_W-1:0]         p_day;
  logic [STAMP_W-1:0]       p_stamp;
  logic [47:0]              out_word;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_day <= 6'sd1;
    end else if (cfg_valid && cfg_ready) begin
      start_day <= signed'(cfg_data);
    end
  end

  // Pipeline advances when the result register is free
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  mps_shift u_shift (
    .year    (s_tdata[11:0]),
    .month   (s_tdata[15:12]),
    .day     (s_tdata[20:16]),
    .offset  (signed'(s_tdata[32:21])),
    .shifted (s1_next)
  );

  // Stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tvalid) begin
      s1 <= s1_next;
    end
  end

  mps_period u_period (
    .shifted      (s1),
    .start_day    (start_day),
    .period_year  (p_year),
    .period_month (p_month),
    .period_day   (p_day),
    .period_stamp (p_stamp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      out_word <= {2'b00, p_stamp, p_day, p_month, p_year};
    end
  end

  assign m_tdata = out_word;

  // A free result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // An accepted word reaches stage one
  a_stage1_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted word lost before stage one");

  // Stage one moves into the result register when the pipe advances
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    v1 && adv |=> m_tvalid)
    else $error("stage one word lost before result register");

  // Result month is always a calendar month
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= MON_MAX))
    else $error("result month out of range");

  // Result day is never zero
  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:16] != 5'd0)
    else $error("result day is zero");

endmodule
